// ----- rtl/mwo_pkg.sv -----
// Shared types and constants for the multi-waveform phase oscillator.
// Holds the per-beat side fields and the quarter-wave cosine table builder.
// Depends on nothing; all other files refer to it by scoped names.
package mwo_pkg;

    localparam int HZ_BITS    = 40;
    localparam int HZ_SPLIT   = 20;
    localparam int FREQ_BITS  = 32;
    localparam int OFF_BITS   = 16;
    localparam int DUTY_BITS  = 17;
    localparam int NPH_BITS   = 32;
    localparam int WIDE_BITS  = 48;
    localparam int PROD_BITS  = 60;

    localparam logic [HZ_BITS-1:0] HZ_RESET    = 40'd6382652534;
    localparam logic [63:0]        HALF_PI_Q30 = 64'd1686629713;

    // (2n-1)*(2n) for n = 1..9
    localparam logic [63:0] COS_DIV [9] = '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
                                            64'd132, 64'd182, 64'd240, 64'd306};

    typedef struct packed {
        logic [OFF_BITS-1:0]  phase_offset;
        logic [DUTY_BITS-1:0] duty;
        logic                 sync;
        logic [NPH_BITS-1:0]  new_phase;
    } item_t;

    // Entry k of the quarter-wave table, Q1.frac, from a truncating Q2.30 series.
    function automatic logic [63:0] cos_entry(input int k, input int ctb, input int frac);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        x    = (HALF_PI_Q30 * 64'(k)) >> ctb;
        x2   = (x * x) >> 30;
        term = 64'd1 << 30;
        sum  = longint'(term);
        for (int n = 1; n <= 9; n++)
        begin
            term = ((term * x2) >> 30) / COS_DIV[n-1];
            if (n % 2 == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        if (sum > (longint'(1) << 30))
            sum = longint'(1) << 30;
        return 64'((sum + (longint'(1) << (29 - frac))) >>> (30 - frac));
    endfunction

endpackage

// ----- rtl/multi_waveform_phase_oscillator_top.sv -----
// Multi-waveform phase oscillator, top level: input register, pipeline control,
// configuration register. Uses mwo_inc_mul, mwo_phase, mwo_wave; depends on mwo_pkg.
//
// Input beats (in_valid/in_ready) carry frequency, phase_offset, duty, sync and
// new_phase. Each accepted beat yields exactly one output beat (out_valid/out_ready)
// with cosine_out, triangle_out, saw_out and square_out, in order.
// Each beat passes through six register stages: input, partial products,
// increment sum, phase accumulator, table read and shaping, output.
// Throughput: one beat per cycle unless out_ready stalls it. The accumulator loop
// is a single add per cycle; the 32 x 40 increment product is split over two stages
// ahead of it, and the cosine table is a ROM with one registered read per beat.
// hz_to_increment is written by cfg_wr_en/cfg_wr_data, taking effect at once;
// write it only while the pipeline is empty.
// Reset clears the phase accumulator, loads the 44.1 kHz factor and empties the
// pipeline. When out_ready is low the output beat holds, earlier stages close up
// their bubbles, and in_ready drops only once every stage is full.
module multi_waveform_phase_oscillator_top #(
    parameter int PHASE_BITS     = 32,
    parameter int COS_TABLE_BITS = 10,
    parameter int OUT_BITS       = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic        [mwo_pkg::HZ_BITS-1:0]    cfg_wr_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [mwo_pkg::FREQ_BITS-1:0]  frequency,
    input  logic        [mwo_pkg::OFF_BITS-1:0]   phase_offset,
    input  logic        [mwo_pkg::DUTY_BITS-1:0]  duty,
    input  logic                                  sync,
    input  logic        [mwo_pkg::NPH_BITS-1:0]   new_phase,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [OUT_BITS-1:0]            cosine_out,
    output logic signed [OUT_BITS-1:0]            triangle_out,
    output logic signed [OUT_BITS-1:0]            saw_out,
    output logic signed [OUT_BITS-1:0]            square_out
);

    localparam int STAGES = 6;

    logic [mwo_pkg::HZ_BITS-1:0]         hz_reg;
    logic [STAGES:1]                     vld_reg;
    logic [STAGES:1]                     vld_next;
    logic [STAGES:1]                     vld_prev;
    logic [STAGES:1]                     stage_en;

    logic signed [mwo_pkg::FREQ_BITS-1:0] freq_reg;
    mwo_pkg::item_t                       s1_item_reg;
    mwo_pkg::item_t                       s2_item_reg;
    mwo_pkg::item_t                       s3_item_reg;

    logic [PHASE_BITS-1:0]                inc;
    logic [PHASE_BITS-1:0]                phase;
    logic [mwo_pkg::DUTY_BITS-1:0]        phase_duty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hz_reg <= mwo_pkg::HZ_RESET;
        else if (cfg_wr_en)
            hz_reg <= cfg_wr_data;
    end

    // a stage advances when empty or when the next one advances
    always_comb
    begin
        stage_en[STAGES] = !vld_reg[STAGES] || out_ready;
        for (int k = STAGES - 1; k >= 1; k--)
            stage_en[k] = !vld_reg[k] || stage_en[k+1];
        vld_prev = {vld_reg[STAGES-1:1], in_valid};
        vld_next = (stage_en & vld_prev) | (~stage_en & vld_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            freq_reg                 <= frequency;
            s1_item_reg.phase_offset <= phase_offset;
            s1_item_reg.duty         <= duty;
            s1_item_reg.sync         <= sync;
            s1_item_reg.new_phase    <= new_phase;
        end
        if (stage_en[2])
            s2_item_reg <= s1_item_reg;
        if (stage_en[3])
            s3_item_reg <= s2_item_reg;
    end

    mwo_inc_mul #(
        .PHASE_BITS (PHASE_BITS)
    ) u_inc_mul (
        .clk             (clk),
        .en_mul          (stage_en[2]),
        .en_sum          (stage_en[3]),
        .frequency       (freq_reg),
        .hz_to_increment (hz_reg),
        .inc             (inc)
    );

    // the accumulator moves only for a real beat
    mwo_phase #(
        .PHASE_BITS (PHASE_BITS)
    ) u_phase (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (stage_en[4] && vld_reg[3]),
        .inc   (inc),
        .item  (s3_item_reg),
        .phase (phase),
        .duty  (phase_duty)
    );

    mwo_wave #(
        .PHASE_BITS     (PHASE_BITS),
        .COS_TABLE_BITS (COS_TABLE_BITS),
        .OUT_BITS       (OUT_BITS)
    ) u_wave (
        .clk          (clk),
        .en_shape     (stage_en[5]),
        .en_out       (stage_en[6]),
        .phase        (phase),
        .duty         (phase_duty),
        .cosine_out   (cosine_out),
        .triangle_out (triangle_out),
        .saw_out      (saw_out),
        .square_out   (square_out)
    );

    assign in_ready  = stage_en[1];
    assign out_valid = vld_reg[STAGES];

endmodule

// ----- rtl/mwo_inc_mul.sv -----
// Phase increment multiplier: frequency times the Hz-to-increment factor.
// Two stages: split partial products, then the shifted sum.
// Depends on mwo_pkg.
module mwo_inc_mul #(
    parameter int PHASE_BITS = 32
) (
    input  logic                                  clk,
    input  logic                                  en_mul,
    input  logic                                  en_sum,
    input  logic signed [mwo_pkg::FREQ_BITS-1:0]  frequency,
    input  logic        [mwo_pkg::HZ_BITS-1:0]    hz_to_increment,
    output logic        [PHASE_BITS-1:0]          inc
);

    localparam int PP_BITS = mwo_pkg::FREQ_BITS + mwo_pkg::HZ_SPLIT + 1;
    localparam int HI_BITS = mwo_pkg::HZ_BITS - mwo_pkg::HZ_SPLIT;

    logic signed [PP_BITS-1:0]             pp_lo_reg;
    logic signed [PP_BITS-1:0]             pp_hi_reg;
    logic signed [mwo_pkg::HZ_SPLIT:0]     hz_lo;
    logic signed [HI_BITS:0]               hz_hi;
    logic [mwo_pkg::PROD_BITS-1:0]         prod;
    logic [PHASE_BITS-1:0]                 inc_reg;

    assign hz_lo = {1'b0, hz_to_increment[mwo_pkg::HZ_SPLIT-1:0]};
    assign hz_hi = {1'b0, hz_to_increment[mwo_pkg::HZ_BITS-1:mwo_pkg::HZ_SPLIT]};

    always_ff @(posedge clk)
    begin
        if (en_mul)
        begin
            pp_lo_reg <= PP_BITS'(frequency) * PP_BITS'(hz_lo);
            pp_hi_reg <= PP_BITS'(frequency) * PP_BITS'(hz_hi);
        end
    end

    // only bits below 60 matter, so the sum wraps there
    assign prod = mwo_pkg::PROD_BITS'(pp_lo_reg)
                + (mwo_pkg::PROD_BITS'(pp_hi_reg) << mwo_pkg::HZ_SPLIT);

    always_ff @(posedge clk)
    begin
        if (en_sum)
            inc_reg <= prod[mwo_pkg::PROD_BITS-1 -: PHASE_BITS];
    end

    assign inc = inc_reg;

endmodule

// ----- rtl/mwo_phase.sv -----
// Phase accumulator stage: sync load, read phase forming and wrap-around advance.
// Depends on mwo_pkg for the side-field struct.
module mwo_phase #(
    parameter int PHASE_BITS = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               load,
    input  logic [PHASE_BITS-1:0]              inc,
    input  mwo_pkg::item_t                     item,
    output logic [PHASE_BITS-1:0]              phase,
    output logic [mwo_pkg::DUTY_BITS-1:0]      duty
);

    localparam int WB = mwo_pkg::WIDE_BITS;

    logic [PHASE_BITS-1:0]            acc_reg;
    logic [PHASE_BITS-1:0]            acc_next;
    logic [PHASE_BITS-1:0]            p_reg;
    logic [PHASE_BITS-1:0]            p_next;
    logic [mwo_pkg::DUTY_BITS-1:0]    duty_reg;
    logic [WB-1:0]                    np_wide;
    logic [WB-1:0]                    off_wide;
    logic [PHASE_BITS-1:0]            base;

    assign np_wide  = {item.new_phase, {(WB - mwo_pkg::NPH_BITS){1'b0}}};
    assign off_wide = {item.phase_offset, {(WB - mwo_pkg::OFF_BITS){1'b0}}};

    always_comb
    begin
        base     = item.sync ? np_wide[WB-1 -: PHASE_BITS] : acc_reg;
        p_next   = base + off_wide[WB-1 -: PHASE_BITS];
        acc_next = base + inc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_reg <= '0;
        else if (load)
            acc_reg <= acc_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            p_reg    <= p_next;
            duty_reg <= item.duty;
        end
    end

    assign phase = p_reg;
    assign duty  = duty_reg;

endmodule

// ----- rtl/mwo_cos_rom.sv -----
// Quarter-wave cosine ROM, 2^COS_TABLE_BITS + 1 entries, registered read.
// Contents come from mwo_pkg::cos_entry at elaboration.
module mwo_cos_rom #(
    parameter int COS_TABLE_BITS = 10,
    parameter int OUT_BITS       = 16
) (
    input  logic                      clk,
    input  logic                      rd_en,
    input  logic [COS_TABLE_BITS:0]   addr,
    output logic [OUT_BITS-1:0]       q
);

    localparam int TAB_N = 1 << COS_TABLE_BITS;

    logic [OUT_BITS-1:0] rom [0:TAB_N];
    logic [OUT_BITS-1:0] q_reg;

    for (genvar k = 0; k <= TAB_N; k++)
    begin : g_rom
        assign rom[k] = OUT_BITS'(mwo_pkg::cos_entry(k, COS_TABLE_BITS, OUT_BITS - 1));
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            q_reg <= rom[addr];
    end

    assign q = q_reg;

endmodule

// ----- rtl/mwo_wave.sv -----
// Waveform shaping: table address, triangle, saw, square, then cosine sign
// and saturation into the output registers. Uses mwo_cos_rom; depends on mwo_pkg.
module mwo_wave #(
    parameter int PHASE_BITS     = 32,
    parameter int COS_TABLE_BITS = 10,
    parameter int OUT_BITS       = 16
) (
    input  logic                               clk,
    input  logic                               en_shape,
    input  logic                               en_out,
    input  logic [PHASE_BITS-1:0]              phase,
    input  logic [mwo_pkg::DUTY_BITS-1:0]      duty,
    output logic signed [OUT_BITS-1:0]         cosine_out,
    output logic signed [OUT_BITS-1:0]         triangle_out,
    output logic signed [OUT_BITS-1:0]         saw_out,
    output logic signed [OUT_BITS-1:0]         square_out
);

    localparam int WB    = mwo_pkg::WIDE_BITS;
    localparam int FRAC  = OUT_BITS - 1;
    localparam int TAB_N = 1 << COS_TABLE_BITS;
    localparam logic [OUT_BITS-1:0] MAX_POS = {1'b0, {FRAC{1'b1}}};
    localparam logic [OUT_BITS-1:0] MIN_NEG = {1'b1, {FRAC{1'b0}}};

    logic [WB-1:0]               p_wide;
    logic [WB-1:0]               m_wide;
    logic [1:0]                  quad;
    logic [COS_TABLE_BITS-1:0]   idx;
    logic [COS_TABLE_BITS:0]     addr;
    logic [OUT_BITS:0]           tri_raw;
    logic [OUT_BITS-1:0]         tri_next;
    logic [OUT_BITS-1:0]         saw_next;
    logic [OUT_BITS-1:0]         sq_next;
    logic [OUT_BITS-1:0]         rom_q;
    logic [OUT_BITS-1:0]         cos_next;

    logic                        neg_reg;
    logic [OUT_BITS-1:0]         tri_reg;
    logic [OUT_BITS-1:0]         saw_reg;
    logic [OUT_BITS-1:0]         sq_reg;
    logic [OUT_BITS-1:0]         cos_out_reg;
    logic [OUT_BITS-1:0]         tri_out_reg;
    logic [OUT_BITS-1:0]         saw_out_reg;
    logic [OUT_BITS-1:0]         sq_out_reg;

    always_comb
    begin
        p_wide = WB'(phase) << (WB - PHASE_BITS);
        quad   = p_wide[WB-1 -: 2];
        idx    = p_wide[WB-3 -: COS_TABLE_BITS];
        // odd quadrants read the table mirrored
        addr   = quad[0] ? ((COS_TABLE_BITS + 1)'(TAB_N) - {1'b0, idx}) : {1'b0, idx};

        m_wide  = p_wide[WB-1] ? (WB'(0) - p_wide) : p_wide;
        tri_raw = (OUT_BITS + 1)'(m_wide >> (WB - 1 - OUT_BITS));
        // only the peak reaches +1
        if (tri_raw[OUT_BITS])
            tri_next = MAX_POS;
        else
            tri_next = {~tri_raw[FRAC], tri_raw[FRAC-1:0]};

        saw_next = {~p_wide[WB-1], p_wide[WB-2 -: FRAC]};
        sq_next  = ({1'b0, p_wide[WB-1 -: 16]} < duty) ? MIN_NEG : MAX_POS;
    end

    mwo_cos_rom #(
        .COS_TABLE_BITS (COS_TABLE_BITS),
        .OUT_BITS       (OUT_BITS)
    ) u_rom (
        .clk   (clk),
        .rd_en (en_shape),
        .addr  (addr),
        .q     (rom_q)
    );

    always_ff @(posedge clk)
    begin
        if (en_shape)
        begin
            neg_reg <= (quad[1] == quad[0]);
            tri_reg <= tri_next;
            saw_reg <= saw_next;
            sq_reg  <= sq_next;
        end
    end

    // entry equal to 1.0 shows up as MIN_NEG's pattern; saturate it when positive
    always_comb
    begin
        if (neg_reg)
            cos_next = OUT_BITS'(0) - rom_q;
        else if (rom_q == MIN_NEG)
            cos_next = MAX_POS;
        else
            cos_next = rom_q;
    end

    always_ff @(posedge clk)
    begin
        if (en_out)
        begin
            cos_out_reg <= cos_next;
            tri_out_reg <= tri_reg;
            saw_out_reg <= saw_reg;
            sq_out_reg  <= sq_reg;
        end
    end

    assign cosine_out   = $signed(cos_out_reg);
    assign triangle_out = $signed(tri_out_reg);
    assign saw_out      = $signed(saw_out_reg);
    assign square_out   = $signed(sq_out_reg);

endmodule
